// ===== hdl/tte_pkg.sv =====
// transposition table engine: shared constants, entry and table access types
// no dependencies
package tte_pkg;

	localparam int ENTRY_COUNT = 4096;
	localparam int IDX_W       = $clog2(ENTRY_COUNT);
	localparam int KEY_W       = 64;
	localparam int DEPTH_W     = 6;
	localparam int SCORE_W     = 18;
	localparam int MOVE_W      = 7;
	localparam int FLAG_W      = 2;

	localparam logic [FLAG_W-1:0] FLAG_EXACT = 2'd0;
	localparam logic [FLAG_W-1:0] FLAG_UPPER = 2'd1;
	localparam logic [FLAG_W-1:0] FLAG_LOWER = 2'd2;

	localparam logic [0:0] ACT_LOOKUP = 1'b0;
	localparam logic [0:0] ACT_STORE  = 1'b1;

	typedef logic [IDX_W-1:0] tte_idx_t;

	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic        [MOVE_W-1:0]  move;
		logic        [DEPTH_W-1:0] depth;
		logic        [FLAG_W-1:0]  flag;
	} tte_entry_t;

	typedef struct packed {
		logic              en;
		tte_idx_t          idx;
		logic [KEY_W-1:0]  key;
		tte_entry_t        entry;
	} tte_wr_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		tte_entry_t        entry;
	} tte_rd_t;

endpackage

// ===== hdl/tte_table.sv =====
// transposition table engine: key and entry memories, clearing sweep after reset,
// last-write forwarding for back-to-back accesses; depends on tte_pkg
module tte_table (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  tte_pkg::tte_idx_t rd_idx,
	input  tte_pkg::tte_wr_t  wr_req,
	output tte_pkg::tte_rd_t  rd_data,
	output logic             busy
);
	import tte_pkg::*;

	logic [KEY_W-1:0] key_mem [ENTRY_COUNT];
	tte_entry_t       entry_mem [ENTRY_COUNT];

	logic             clr_busy_q;
	tte_idx_t         clr_idx_q;

	logic             we;
	tte_idx_t         widx;
	logic [KEY_W-1:0] wkey;
	tte_entry_t       wentry;

	tte_idx_t         rd_idx_q;
	logic [KEY_W-1:0] rd_key_q;
	tte_entry_t       rd_entry_q;

	logic             fwd_valid_q;
	tte_idx_t         fwd_idx_q;
	logic [KEY_W-1:0] fwd_key_q;
	tte_entry_t       fwd_entry_q;

	// clearing sweep, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == IDX_W'(ENTRY_COUNT - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign we     = clr_busy_q | wr_req.en;
	assign widx   = clr_busy_q ? clr_idx_q : wr_req.idx;
	assign wkey   = clr_busy_q ? '0 : wr_req.key;
	assign wentry = clr_busy_q ? '0 : wr_req.entry;

	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[widx]   <= wkey;
			entry_mem[widx] <= wentry;
		end
		if (rd_en) begin
			rd_idx_q   <= rd_idx;
			rd_key_q   <= key_mem[rd_idx];
			rd_entry_q <= entry_mem[rd_idx];
		end
	end

	// most recent write, always equal to memory contents at its index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (we) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			fwd_idx_q   <= widx;
			fwd_key_q   <= wkey;
			fwd_entry_q <= wentry;
		end
	end

	always_comb begin
		if (fwd_valid_q && fwd_idx_q == rd_idx_q) begin
			rd_data.key   = fwd_key_q;
			rd_data.entry = fwd_entry_q;
		end else begin
			rd_data.key   = rd_key_q;
			rd_data.entry = rd_entry_q;
		end
	end

	assign busy = clr_busy_q;

endmodule

// ===== hdl/tte_ctrl.sv =====
// transposition table engine: handshakes, compare and replace stage, result register
// depends on tte_pkg
module tte_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        action,
	input  logic [tte_pkg::KEY_W-1:0]   key,
	input  logic [tte_pkg::DEPTH_W-1:0] depth,
	input  logic signed [tte_pkg::SCORE_W-1:0] alpha,
	input  logic signed [tte_pkg::SCORE_W-1:0] beta,
	input  logic signed [tte_pkg::SCORE_W-1:0] entry_score,
	input  logic signed [tte_pkg::MOVE_W-1:0]  entry_move,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        hit,
	output logic                        key_matched,
	output logic signed [tte_pkg::SCORE_W-1:0] found_score,
	output logic signed [tte_pkg::MOVE_W-1:0]  found_move,
	output logic                        written,
	input  logic                        tbl_busy,
	input  tte_pkg::tte_rd_t            rd_data,
	output logic                        rd_en,
	output tte_pkg::tte_idx_t           rd_idx,
	output tte_pkg::tte_wr_t            wr_req
);
	import tte_pkg::*;

	logic                      s1_valid_q;
	logic                      action_s1;
	logic [KEY_W-1:0]          key_s1;
	logic [DEPTH_W-1:0]        depth_s1;
	logic signed [SCORE_W-1:0] alpha_s1;
	logic signed [SCORE_W-1:0] beta_s1;
	logic signed [SCORE_W-1:0] score_s1;
	logic [MOVE_W-1:0]         move_s1;

	logic                      accept;
	logic                      s1_adv;
	logic                      match;
	logic                      depth_ok;
	logic                      flag_ok;
	logic                      lk_hit;
	logic                      do_wr;
	logic [FLAG_W-1:0]         new_flag;
	tte_entry_t                cur;

	logic                      out_valid_q;
	logic                      hit_q;
	logic                      matched_q;
	logic signed [SCORE_W-1:0] score_q;
	logic [MOVE_W-1:0]         move_q;
	logic                      written_q;

	assign s1_adv   = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = tbl_busy || (s1_valid_q && !s1_adv);
	assign accept   = in_valid && !in_stall;
	assign rd_en    = accept;
	assign rd_idx   = key[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			key_s1    <= key;
			depth_s1  <= depth;
			alpha_s1  <= alpha;
			beta_s1   <= beta;
			score_s1  <= entry_score;
			move_s1   <= entry_move;
		end
	end

	assign cur      = rd_data.entry;
	assign match    = rd_data.key == key_s1;
	assign depth_ok = cur.depth >= depth_s1;
	assign flag_ok  = (cur.flag == FLAG_EXACT)
		|| (cur.flag == FLAG_UPPER && cur.score <= alpha_s1)
		|| (cur.flag == FLAG_LOWER && cur.score >= beta_s1);
	assign lk_hit   = match && depth_ok && flag_ok;
	assign do_wr    = (rd_data.key == '0) || !match || (depth_s1 >= cur.depth);

	always_comb begin
		if (score_s1 <= alpha_s1) begin
			new_flag = FLAG_UPPER;
		end else if (score_s1 >= beta_s1) begin
			new_flag = FLAG_LOWER;
		end else begin
			new_flag = FLAG_EXACT;
		end
	end

	always_comb begin
		wr_req.en          = s1_adv && (action_s1 == ACT_STORE) && do_wr;
		wr_req.idx         = key_s1[IDX_W-1:0];
		wr_req.key         = key_s1;
		wr_req.entry.score = score_s1;
		wr_req.entry.move  = move_s1;
		wr_req.entry.depth = depth_s1;
		wr_req.entry.flag  = new_flag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			if (action_s1 == ACT_LOOKUP) begin
				hit_q     <= lk_hit;
				matched_q <= match;
				score_q   <= lk_hit ? cur.score : '0;
				move_q    <= match ? cur.move : '1;
				written_q <= 1'b0;
			end else begin
				hit_q     <= 1'b0;
				matched_q <= 1'b0;
				score_q   <= '0;
				move_q    <= '1;
				written_q <= do_wr;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign key_matched = matched_q;
	assign found_score = score_q;
	assign found_move  = move_q;
	assign written     = written_q;

endmodule

// ===== hdl/transposition_table_engine.sv =====
// transposition table engine, top level; depends on tte_pkg, tte_ctrl, tte_table
// a beat accepted passes the read stage, then the result register
// throughput: one beat per cycle unless out_stall holds, set by the single read and
// write port of the table memory with last-write forwarding between consecutive
// accesses to one entry; reset: a clearing sweep writes all 4096 entries to zero,
// one per cycle, and in_stall stays high until the sweep is done
module transposition_table_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        action,
	input  logic [tte_pkg::KEY_W-1:0]   key,
	input  logic [tte_pkg::DEPTH_W-1:0] depth,
	input  logic signed [tte_pkg::SCORE_W-1:0] alpha,
	input  logic signed [tte_pkg::SCORE_W-1:0] beta,
	input  logic signed [tte_pkg::SCORE_W-1:0] entry_score,
	input  logic signed [tte_pkg::MOVE_W-1:0]  entry_move,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        hit,
	output logic                        key_matched,
	output logic signed [tte_pkg::SCORE_W-1:0] found_score,
	output logic signed [tte_pkg::MOVE_W-1:0]  found_move,
	output logic                        written
);
	import tte_pkg::*;

	logic     tbl_busy;
	logic     rd_en;
	tte_idx_t rd_idx;
	tte_wr_t  wr_req;
	tte_rd_t  rd_data;

	tte_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.key         (key),
		.depth       (depth),
		.alpha       (alpha),
		.beta        (beta),
		.entry_score (entry_score),
		.entry_move  (entry_move),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.key_matched (key_matched),
		.found_score (found_score),
		.found_move  (found_move),
		.written     (written),
		.tbl_busy    (tbl_busy),
		.rd_data     (rd_data),
		.rd_en       (rd_en),
		.rd_idx      (rd_idx),
		.wr_req      (wr_req)
	);

	tte_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_idx  (rd_idx),
		.wr_req  (wr_req),
		.rd_data (rd_data),
		.busy    (tbl_busy)
	);

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// testbench for transposition_table_engine: random and directed lookups and stores,
// checked beat by beat against a table kept alongside the block
// depends on tte_pkg and the transposition_table_engine RTL
module tb_top;
	import tte_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int RAND_BEATS  = 1000;

	typedef struct {
		logic                      action;
		logic [KEY_W-1:0]          key;
		logic [DEPTH_W-1:0]        depth;
		logic signed [SCORE_W-1:0] alpha;
		logic signed [SCORE_W-1:0] beta;
		logic signed [SCORE_W-1:0] score;
		logic signed [MOVE_W-1:0]  move;
		int                        gap;
	} tt_beat_t;

	typedef struct {
		logic                      hit;
		logic                      matched;
		logic signed [SCORE_W-1:0] score;
		logic signed [MOVE_W-1:0]  move;
		logic                      written;
	} tt_resp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = 1'b0;
	logic [KEY_W-1:0] key = '0;
	logic [DEPTH_W-1:0] depth = '0;
	logic signed [SCORE_W-1:0] alpha = '0;
	logic signed [SCORE_W-1:0] beta = '0;
	logic signed [SCORE_W-1:0] entry_score = '0;
	logic signed [MOVE_W-1:0] entry_move = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit;
	logic key_matched;
	logic signed [SCORE_W-1:0] found_score;
	logic signed [MOVE_W-1:0] found_move;
	logic written;

	// shadow table
	logic [KEY_W-1:0] tt_keys [ENTRY_COUNT];
	tte_entry_t       tt_slots [ENTRY_COUNT];

	tt_beat_t beat_q[$];
	tt_resp_t tt_resp_q[$];
	tt_beat_t cur_beat;
	tt_resp_t due;
	tt_resp_t chk;
	logic [KEY_W-1:0] key_pool [20];

	int beat_total = 0;
	int sent_cnt = 0;
	int rcv_cnt = 0;
	int err_cnt = 0;
	int n_store = 0, n_written = 0, n_lookup = 0, n_matched = 0, n_hit = 0;
	int tx_mode = 1;
	int tx_wait = -1;
	int rx_mode = 1;
	int rx_wait = 0;
	int hold_left = 0;
	int idle_cyc = 0;
	int pressure_cnt = 0;

	transposition_table_engine i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.key         (key),
		.depth       (depth),
		.alpha       (alpha),
		.beta        (beta),
		.entry_score (entry_score),
		.entry_move  (entry_move),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.key_matched (key_matched),
		.found_score (found_score),
		.found_move  (found_move),
		.written     (written)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int draw_gap(int mode);
		if (mode == 0)
			return 0;
		if (mode == 2)
			return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 17)) : 0;
		return int'($urandom_range(0, 17));
	endfunction

	function automatic int pick_score();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return int'($urandom_range(0, 40)) - 20;
			6: return -131072;
			7: return 131071;
			default: return int'($signed(SCORE_W'($urandom)));
		endcase
	endfunction

	function automatic tt_resp_t tt_access(tt_beat_t b);
		tt_resp_t   r;
		int         slot;
		tte_entry_t e;
		logic [FLAG_W-1:0] fl;
		r.hit = 1'b0;
		r.matched = 1'b0;
		r.score = '0;
		r.move = '1;
		r.written = 1'b0;
		slot = int'(b.key % 64'(ENTRY_COUNT));
		e = tt_slots[slot];
		if (b.action == ACT_LOOKUP) begin
			if (tt_keys[slot] == b.key) begin
				r.matched = 1'b1;
				r.move = e.move;
				if (e.depth >= b.depth && (e.flag == FLAG_EXACT ||
						(e.flag == FLAG_UPPER && e.score <= b.alpha) ||
						(e.flag == FLAG_LOWER && e.score >= b.beta))) begin
					r.hit = 1'b1;
					r.score = e.score;
				end
			end
		end else if (tt_keys[slot] == '0 || tt_keys[slot] != b.key || b.depth >= e.depth) begin
			if (b.score <= b.alpha)
				fl = FLAG_UPPER;
			else if (b.score >= b.beta)
				fl = FLAG_LOWER;
			else
				fl = FLAG_EXACT;
			tt_keys[slot] = b.key;
			e.score = b.score;
			e.move = b.move;
			e.depth = b.depth;
			e.flag = fl;
			tt_slots[slot] = e;
			r.written = 1'b1;
		end
		return r;
	endfunction

	task automatic add_beat(logic act, logic [KEY_W-1:0] k, int d, int a, int bt, int s, int m);
		tt_beat_t b;
		if (beat_total % 64 == 0)
			tx_mode = $urandom_range(0, 2);
		b.action = act;
		b.key = k;
		b.depth = DEPTH_W'(d);
		b.alpha = SCORE_W'(a);
		b.beta = SCORE_W'(bt);
		b.score = SCORE_W'(s);
		b.move = MOVE_W'(m);
		b.gap = draw_gap(tx_mode);
		beat_q.push_back(b);
		beat_total++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_wait = -1;
		end else begin
			if (in_valid && !in_stall) begin
				due = tt_access(cur_beat);
				tt_resp_q.push_back(due);
				sent_cnt++;
				if (cur_beat.action == ACT_STORE) begin
					n_store++;
					n_written += due.written;
				end else begin
					n_lookup++;
					n_matched += due.matched;
					n_hit += due.hit;
				end
			end
			if (!in_valid || !in_stall) begin
				if (beat_q.size() == 0) begin
					in_valid <= 1'b0;
				end else begin
					if (tx_wait < 0)
						tx_wait = beat_q[0].gap;
					if (tx_wait == 0) begin
						cur_beat = beat_q.pop_front();
						tx_wait = -1;
						in_valid <= 1'b1;
						action <= cur_beat.action;
						key <= cur_beat.key;
						depth <= cur_beat.depth;
						alpha <= cur_beat.alpha;
						beta <= cur_beat.beta;
						entry_score <= cur_beat.score;
						entry_move <= cur_beat.move;
					end else begin
						in_valid <= 1'b0;
						tx_wait--;
					end
				end
			end
		end
	end

	// monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_wait = 0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				rcv_cnt++;
				if (tt_resp_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("%0t: result beat with nothing expected", $realtime);
				end else begin
					chk = tt_resp_q.pop_front();
					if (hit !== chk.hit || key_matched !== chk.matched ||
							found_score !== chk.score || found_move !== chk.move ||
							written !== chk.written) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("%0t: beat %0d exp %b %b %0d %0d %b, got %b %b %0d %0d %b",
								$realtime, rcv_cnt, chk.hit, chk.matched, chk.score,
								chk.move, chk.written, hit, key_matched, found_score,
								found_move, written);
					end
				end
				if (rcv_cnt % 64 == 0)
					rx_mode = $urandom_range(0, 2);
				rx_wait = draw_gap(rx_mode);
				// long hold-off so the block backs up into its input
				if (rcv_cnt == 300 || rcv_cnt == 750) begin
					hold_left = 400;
					pressure_cnt++;
				end
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (rx_wait > 0) begin
				out_stall <= 1'b1;
				rx_wait--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cyc <= 0;
			end else begin
				idle_cyc <= idle_cyc + 1;
				if (idle_cyc >= STALL_LIMIT) begin
					$display("%0t: no progress for %0d cycles", $realtime, idle_cyc);
					$display("Verification failed");
					$finish;
				end
			end
		end
	end

	initial begin
		logic [KEY_W-1:0] k1, k2, k3, kx, kr;
		logic act;
		int   pick;
		int   d;
		k1 = 64'h0123_4567_89AB_C005;
		k2 = 64'hFEDC_BA98_7654_3A11;
		k3 = 64'h5A5A_0F0F_3C3C_0777;
		kx = '1;

		// cleared table and zero key
		add_beat(ACT_LOOKUP, '0, 0, 0, 0, 5, 3);
		add_beat(ACT_LOOKUP, '0, 63, 0, 0, 0, 0);
		add_beat(ACT_LOOKUP, kx, 0, 0, 0, 0, 0);
		// exact entry, depth check, shallower store refused, equal depth replaces
		add_beat(ACT_STORE, k1, 10, -5, 5, 0, 63);
		add_beat(ACT_LOOKUP, k1, 10, 0, 0, 0, 0);
		add_beat(ACT_LOOKUP, k1, 11, 0, 0, 0, 0);
		add_beat(ACT_STORE, k1, 9, -5, 5, 100, 1);
		add_beat(ACT_STORE, k1, 10, -131072, 131071, -131072, -1);
		add_beat(ACT_LOOKUP, k1, 0, -131072, 0, 0, 0);
		// upper bound entry
		add_beat(ACT_STORE, k2, 5, -100, 100, -100, -1);
		add_beat(ACT_LOOKUP, k2, 5, -101, 0, 0, 0);
		add_beat(ACT_LOOKUP, k2, 5, -100, 0, 0, 0);
		// lower bound entry
		add_beat(ACT_STORE, k2, 5, 0, 50, 50, 0);
		add_beat(ACT_LOOKUP, k2, 5, 0, 51, 0, 0);
		add_beat(ACT_LOOKUP, k2, 5, 0, 50, 0, 0);
		// inverted windows
		add_beat(ACT_STORE, k3, 63, 10, -10, 5, 7);
		add_beat(ACT_STORE, k3, 63, -10, -20, 0, 8);
		add_beat(ACT_LOOKUP, k3, 63, 131071, -20, 0, 0);
		// other key on the same slot always replaces
		add_beat(ACT_STORE, k3 ^ 64'h8000_0000_0000_0000, 0, 0, 0, 1, 2);
		add_beat(ACT_LOOKUP, k3, 0, 0, 0, 0, 0);
		// zero key slot is always overwritten
		add_beat(ACT_STORE, '0, 63, -131072, 131071, 7, 9);
		add_beat(ACT_STORE, 64'(ENTRY_COUNT), 0, -131072, 131071, 0, 10);
		// all-ones key at the extremes
		add_beat(ACT_STORE, kx, 63, -131072, 131071, 131071, 63);
		add_beat(ACT_LOOKUP, kx, 63, 0, 131071, 0, 0);
		add_beat(ACT_STORE, kx, 62, 0, 0, 0, 0);

		// key pool with slot collisions so lookups find stored entries
		key_pool[0] = '0;
		key_pool[1] = '1;
		key_pool[2] = 64'h8000_0000_0000_0000;
		for (int i = 3; i < 11; i++)
			key_pool[i] = {$urandom, $urandom};
		for (int i = 11; i < 17; i++)
			key_pool[i] = {$urandom, 20'($urandom), key_pool[i - 8][IDX_W-1:0]};
		for (int i = 17; i < 20; i++)
			key_pool[i] = {$urandom, 20'($urandom), 12'($urandom_range(0, 3))};

		for (int n = 0; n < RAND_BEATS; n++) begin
			act = 1'($urandom_range(0, 1));
			pick = $urandom_range(0, 19);
			if ($urandom_range(0, 9) == 0)
				kr = {$urandom, $urandom};
			else
				kr = key_pool[pick];
			if ($urandom_range(0, 1) == 0)
				d = $urandom_range(0, 63);
			else
				d = $urandom_range(0, 8);
			add_beat(act, kr, d, pick_score(), pick_score(), pick_score(),
				int'($urandom_range(0, 64)) - 1);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (sent_cnt < beat_total)
			@(posedge clk);
		while (tt_resp_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("run covered %0d beats: %0d stores (%0d written), %0d lookups",
			sent_cnt, n_store, n_written, n_lookup);
		$display("%0d matched, %0d hit, %0d results checked, %0d long hold-offs, %0d mismatches",
			n_matched, n_hit, rcv_cnt, pressure_cnt, err_cnt);
		if (err_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		for (int i = 0; i < ENTRY_COUNT; i++) begin
			tt_keys[i] = '0;
			tt_slots[i] = '0;
		end
	end

endmodule
